@@ design/conv3x3_normalized_clamp_filter_unit_defines.svh @@
// Assertion macros used by the filter unit's controller.
`ifndef CONV3X3_NORMALIZED_CLAMP_FILTER_UNIT_DEFINES_SVH
`define CONV3X3_NORMALIZED_CLAMP_FILTER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define CNV3_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define CNV3_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/cnv3_pkg.sv @@
// Types, constants and helpers shared by the 3x3 filter unit.
package cnv3_pkg;

	localparam int MAX_WIDTH  = 256;
	localparam int LINE_DEPTH = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
	localparam int COL_W      = $clog2(LINE_DEPTH);
	localparam int DIM_W      = 9;
	localparam int PIX_W      = 8;
	localparam int POS_W      = 8;
	localparam int CFG_W      = 36;
	localparam int CFG_IDX_W  = 3;
	localparam int COEF_W     = 12;
	localparam int PROD_W     = PIX_W + 1 + COEF_W;
	localparam int ACC_W      = 24;
	localparam int CSUM_W     = 16;
	localparam int DVS_W      = 15;
	localparam int STEP_W     = 5;
	localparam int MAC_TAPS   = 9;
	localparam int DIV_STEPS  = ACC_W;

	localparam logic [DIM_W-1:0] WIDTH_CAP  = DIM_W'(LINE_DEPTH);
	localparam logic [DIM_W-1:0] HEIGHT_CAP = DIM_W'(256);
	localparam logic [PIX_W-1:0] PIX_MAX    = PIX_W'(255);
	localparam logic [DVS_W-1:0] Q74_ONE    = DVS_W'(16);

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_COEFF_TOP    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COEFF_MID    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COEFF_BOTTOM = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd4;

	localparam logic KIND_DRAIN = 1'b1;

	typedef struct packed {
		logic             kind;
		logic [PIX_W-1:0] pixel_value;
	} in_t;

	typedef struct packed {
		logic [PIX_W-1:0] out_value;
		logic [POS_W-1:0] out_row;
		logic [POS_W-1:0] out_col;
		logic             frame_last;
	} out_t;

	typedef struct packed {
		logic load_item;
		logic check;
		logic update;
		logic mac_step;
		logic div_init;
		logic div_step;
		logic push_out;
	} cmd_t;

	typedef struct packed {
		logic skip;
		logic need_res;
		logic use_conv;
		logic mac_last;
		logic div_last;
		logic out_full;
	} sts_t;

	// Coefficient of window tap k (row-major), left column in the low bits.
	function automatic logic signed [COEF_W-1:0] coeff_sel(
		input logic [CFG_W-1:0] top,
		input logic [CFG_W-1:0] mid,
		input logic [CFG_W-1:0] bot,
		input logic [3:0]       k
	);
		logic [COEF_W-1:0] c;
		case (k)
			4'd0: c = top[11:0];
			4'd1: c = top[23:12];
			4'd2: c = top[35:24];
			4'd3: c = mid[11:0];
			4'd4: c = mid[23:12];
			4'd5: c = mid[35:24];
			4'd6: c = bot[11:0];
			4'd7: c = bot[23:12];
			4'd8: c = bot[35:24];
			default: c = '0;
		endcase
		return $signed(c);
	endfunction

endpackage

@@ design/cnv3_dp.sv @@
// Datapath: configuration, line stores, window, counters, MAC, divider, output register.
module cnv3_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [cnv3_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cnv3_pkg::CFG_W-1:0]      cfg_data,
	input  cnv3_pkg::in_t                   in_data,
	input  logic                            out_ready,
	input  cnv3_pkg::cmd_t                  cmd,
	output cnv3_pkg::sts_t                  sts,
	output logic                            out_valid,
	output cnv3_pkg::out_t                  out_data
);

	localparam int DW = cnv3_pkg::DIM_W;
	localparam int PW = cnv3_pkg::PIX_W;

	logic [cnv3_pkg::CFG_W-1:0] coef_top_q, coef_mid_q, coef_bot_q;
	logic [DW-1:0] width_q, height_q, w_eff, h_eff;

	logic          kind_q;
	logic [PW-1:0] pix_q, pix_eff;

	logic [cnv3_pkg::COL_W-1:0] col_q, ic_addr;
	logic [DW-1:0]              row_q;
	logic [cnv3_pkg::POS_W-1:0] orow_q, ocol_q;

	logic [PW-1:0] older_mem [cnv3_pkg::LINE_DEPTH];
	logic [PW-1:0] newer_mem [cnv3_pkg::LINE_DEPTH];
	logic [PW-1:0] rd_older_q, rd_newer_q;
	logic [PW-1:0] win_q [9];

	logic [cnv3_pkg::POS_W-1:0] res_row_q, res_col_q;
	logic                       res_last_q;
	logic [PW-1:0]              res_val_q;
	logic                       conv_q;

	logic signed [cnv3_pkg::ACC_W-1:0]  acc_q;
	logic signed [cnv3_pkg::CSUM_W-1:0] csum_q;
	logic [cnv3_pkg::STEP_W-1:0]        step_q;
	logic [cnv3_pkg::ACC_W-1:0]         dvd_q;
	logic [cnv3_pkg::DVS_W-1:0]         dvs_q, rem_q;
	logic                               neg_q;

	logic                   out_valid_q;
	cnv3_pkg::out_t         out_q;

	logic          col_ge_w, need, interior, last, col_wrap, ocol_wrap, dim_write;
	logic [DW-1:0] col_nx, orow9, ocol9;
	logic signed [cnv3_pkg::COEF_W-1:0] coef_k;
	logic signed [cnv3_pkg::PROD_W-1:0] prod;
	logic [cnv3_pkg::DVS_W:0]           trial;
	logic                               trial_ge;
	logic [PW-1:0]                      conv_val;

	// Effective frame size: zero reads as one, larger values saturate
	always_comb begin
		if (width_q == '0) w_eff = DW'(1);
		else if (width_q > cnv3_pkg::WIDTH_CAP) w_eff = cnv3_pkg::WIDTH_CAP;
		else w_eff = width_q;
		if (height_q == '0) h_eff = DW'(1);
		else if (height_q > cnv3_pkg::HEIGHT_CAP) h_eff = cnv3_pkg::HEIGHT_CAP;
		else h_eff = height_q;
	end

	assign pix_eff  = (kind_q == cnv3_pkg::KIND_DRAIN) ? '0 : pix_q;
	assign col_ge_w = DW'(col_q) >= w_eff;
	assign ic_addr  = col_ge_w ? '0 : col_q;
	assign col_nx   = DW'(col_q) + DW'(1);
	assign col_wrap = col_nx >= w_eff;
	assign orow9    = DW'(orow_q);
	assign ocol9    = DW'(ocol_q);
	assign need     = (row_q >= DW'(2)) || ((row_q == DW'(1)) && (col_q != '0));
	assign interior = (orow_q != '0) && ((orow9 + DW'(2)) <= h_eff)
		&& (ocol_q != '0) && ((ocol9 + DW'(2)) <= w_eff);
	assign last      = (orow9 == h_eff - DW'(1)) && (ocol9 == w_eff - DW'(1));
	assign ocol_wrap = (ocol9 + DW'(1)) == w_eff;
	assign dim_write = cfg_we && ((cfg_index == cnv3_pkg::CFG_IMAGE_WIDTH)
		|| (cfg_index == cnv3_pkg::CFG_IMAGE_HEIGHT));

	assign sts.skip     = (kind_q == cnv3_pkg::KIND_DRAIN) && (row_q == '0) && (col_q == '0);
	assign sts.need_res = need;
	assign sts.use_conv = need && (col_q != '0) && interior;
	assign sts.mac_last = step_q == cnv3_pkg::STEP_W'(cnv3_pkg::MAC_TAPS - 1);
	assign sts.div_last = step_q == cnv3_pkg::STEP_W'(cnv3_pkg::DIV_STEPS - 1);
	assign sts.out_full = out_valid_q && !out_ready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_top_q <= '0;
			coef_mid_q <= cnv3_pkg::CFG_W'(65536);
			coef_bot_q <= '0;
			width_q    <= DW'(256);
			height_q   <= DW'(256);
		end else if (cfg_we) begin
			case (cfg_index)
				cnv3_pkg::CFG_COEFF_TOP:    coef_top_q <= cfg_data;
				cnv3_pkg::CFG_COEFF_MID:    coef_mid_q <= cfg_data;
				cnv3_pkg::CFG_COEFF_BOTTOM: coef_bot_q <= cfg_data;
				cnv3_pkg::CFG_IMAGE_WIDTH:  width_q    <= cfg_data[DW-1:0];
				cnv3_pkg::CFG_IMAGE_HEIGHT: height_q   <= cfg_data[DW-1:0];
				default: ;
			endcase
		end
	end

	// Frame counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			orow_q <= '0;
			ocol_q <= '0;
		end else if (dim_write || (cmd.check && col_ge_w)) begin
			col_q  <= '0;
			row_q  <= '0;
			orow_q <= '0;
			ocol_q <= '0;
		end else if (cmd.update) begin
			if (need && last) begin
				col_q  <= '0;
				row_q  <= '0;
				orow_q <= '0;
				ocol_q <= '0;
			end else begin
				if (col_wrap) begin
					col_q <= '0;
					row_q <= row_q + DW'(1);
				end else begin
					col_q <= col_nx[cnv3_pkg::COL_W-1:0];
				end
				if (need) begin
					if (ocol_wrap) begin
						ocol_q <= '0;
						orow_q <= orow_q + cnv3_pkg::POS_W'(1);
					end else begin
						ocol_q <= ocol_q + cnv3_pkg::POS_W'(1);
					end
				end
			end
		end
	end

	// Window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) win_q[i] <= '0;
		end else if (cmd.update) begin
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
			win_q[2] <= rd_older_q;
			win_q[3] <= win_q[4];
			win_q[4] <= win_q[5];
			win_q[5] <= rd_newer_q;
			win_q[6] <= win_q[7];
			win_q[7] <= win_q[8];
			win_q[8] <= pix_eff;
		end
	end

	// Line stores: read on check, write back on update
	always_ff @(posedge clk) begin
		if (cmd.check) begin
			rd_older_q <= older_mem[ic_addr];
			rd_newer_q <= newer_mem[ic_addr];
		end
		if (cmd.update) begin
			older_mem[col_q] <= rd_newer_q;
			newer_mem[col_q] <= pix_eff;
		end
	end

	assign coef_k   = cnv3_pkg::coeff_sel(coef_top_q, coef_mid_q, coef_bot_q, step_q[3:0]);
	assign prod     = $signed({1'b0, win_q[step_q[3:0]]}) * coef_k;
	assign trial    = {rem_q, dvd_q[cnv3_pkg::ACC_W-1]};
	assign trial_ge = trial >= {1'b0, dvs_q};

	// Item capture, result staging, MAC and divider
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			kind_q <= in_data.kind;
			pix_q  <= in_data.pixel_value;
		end
		if (cmd.update) begin
			res_row_q  <= orow_q;
			res_col_q  <= ocol_q;
			res_last_q <= last;
			res_val_q  <= win_q[5];
			conv_q     <= sts.use_conv;
			acc_q      <= '0;
			csum_q     <= '0;
			step_q     <= '0;
		end else if (cmd.mac_step) begin
			acc_q  <= acc_q + cnv3_pkg::ACC_W'(prod);
			csum_q <= csum_q + cnv3_pkg::CSUM_W'(coef_k);
			step_q <= step_q + cnv3_pkg::STEP_W'(1);
		end else if (cmd.div_init) begin
			dvd_q  <= acc_q[cnv3_pkg::ACC_W-1] ? cnv3_pkg::ACC_W'(-acc_q) : acc_q;
			rem_q  <= '0;
			step_q <= '0;
			if (csum_q == '0) begin
				dvs_q <= cnv3_pkg::Q74_ONE;
				neg_q <= acc_q[cnv3_pkg::ACC_W-1];
			end else begin
				dvs_q <= csum_q[cnv3_pkg::CSUM_W-1] ? cnv3_pkg::DVS_W'(-csum_q)
					: cnv3_pkg::DVS_W'(csum_q);
				neg_q <= acc_q[cnv3_pkg::ACC_W-1] ^ csum_q[cnv3_pkg::CSUM_W-1];
			end
		end else if (cmd.div_step) begin
			rem_q  <= trial_ge ? cnv3_pkg::DVS_W'(trial - {1'b0, dvs_q}) : trial[cnv3_pkg::DVS_W-1:0];
			dvd_q  <= {dvd_q[cnv3_pkg::ACC_W-2:0], trial_ge};
			step_q <= step_q + cnv3_pkg::STEP_W'(1);
		end
	end

	// Clamp the quotient magnitude: negative goes to zero, above 255 to 255
	always_comb begin
		if (neg_q) conv_val = '0;
		else if (dvd_q > cnv3_pkg::ACC_W'(cnv3_pkg::PIX_MAX)) conv_val = cnv3_pkg::PIX_MAX;
		else conv_val = dvd_q[PW-1:0];
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push_out) begin
			out_q.out_value  <= conv_q ? conv_val : res_val_q;
			out_q.out_row    <= res_row_q;
			out_q.out_col    <= res_col_q;
			out_q.frame_last <= res_last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ design/cnv3_ctrl.sv @@
// Controller: sequences each request through check, update and, where needed, MAC, divide and push.
`include "conv3x3_normalized_clamp_filter_unit_defines.svh"

module cnv3_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  cnv3_pkg::sts_t sts,
	output logic           in_ready,
	output cnv3_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_UPDATE,
		S_MAC,
		S_DIVINIT,
		S_DIV,
		S_PUSH
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE:    if (in_valid) state_q <= S_CHECK;
				S_CHECK:   state_q <= sts.skip ? S_IDLE : S_UPDATE;
				S_UPDATE: begin
					if (!sts.need_res) state_q <= S_IDLE;
					else if (sts.use_conv) state_q <= S_MAC;
					else state_q <= S_PUSH;
				end
				S_MAC:     if (sts.mac_last) state_q <= S_DIVINIT;
				S_DIVINIT: state_q <= S_DIV;
				S_DIV:     if (sts.div_last) state_q <= S_PUSH;
				S_PUSH:    if (!sts.out_full) state_q <= S_IDLE;
				default:   state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready = state_q == S_IDLE;

	always_comb begin
		cmd           = '0;
		cmd.load_item = (state_q == S_IDLE) && in_valid;
		cmd.check     = state_q == S_CHECK && !sts.skip;
		cmd.update    = state_q == S_UPDATE;
		cmd.mac_step  = state_q == S_MAC;
		cmd.div_init  = state_q == S_DIVINIT;
		cmd.div_step  = state_q == S_DIV;
		cmd.push_out  = (state_q == S_PUSH) && !sts.out_full;
	end

	`CNV3_ASSERT_IMPL(a_idle_no_work, in_ready, !cmd.mac_step && !cmd.div_step && !cmd.push_out, "arithmetic while accepting")
	`CNV3_ASSERT_NEXT(a_push_returns, cmd.push_out, in_ready, "no return to idle after push")
	`CNV3_ASSERT_NEXT(a_div_to_push, (state_q == S_DIV) && sts.div_last, state_q == S_PUSH, "divider end missed")

endmodule

@@ design/conv3x3_normalized_clamp_filter_unit.sv @@
// Top level of the 3x3 normalized, clamped convolution filter unit.
//
// Streams 8-bit grey pixels in raster order and returns one filtered pixel per
// request, lagging the input by image_width+1 positions; the first
// image_width+1 requests of a frame give no result, and drain requests
// (kind = 1) after the frame's last pixel flush the tail. Interior pixels are
// sum(pixel * Q7.4 coefficient) divided by the coefficient sum (truncated toward
// zero; a zero sum divides by 16 instead), clamped to 0..255; border pixels
// pass through. A convolved result goes through accept, line store read, window
// update, a 3x3 MAC through one 8x12 multiplier, divider load, a restoring
// divider at one quotient bit per cycle, and the push into the output register.
// Border results skip the MAC and divider, requests without a result end after
// the window update, and a drain with no frame in progress ends at the check.
// The output register lets the next request be accepted while a result waits.
// Configuration writes take effect at once; writing the width or height abandons
// the frame in progress. The line stores need no clearing after reset.
module conv3x3_normalized_clamp_filter_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [cnv3_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cnv3_pkg::CFG_W-1:0]      cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  cnv3_pkg::in_t                   in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output cnv3_pkg::out_t                  out_data
);

	cnv3_pkg::cmd_t cmd;
	cnv3_pkg::sts_t sts;

	// Sequencer: one request in flight at a time
	cnv3_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	// Storage and arithmetic, sequenced by the command bundle; configuration writes reach it directly
	cnv3_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule
